// ===== hw/rtl/frame_pacing_deadline_timer_assert.svh =====
// Assertion macros for the frame pacing deadline timer.
// FPDT_ASSERT checks on clk_i with reset masked; FPDT_ASSERT_RST also checks during reset.
`ifndef FRAME_PACING_DEADLINE_TIMER_ASSERT_SVH
`define FRAME_PACING_DEADLINE_TIMER_ASSERT_SVH

`ifndef SYNTHESIS
`define FPDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FPDT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FPDT_ASSERT(label, prop, msg)
`define FPDT_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== hw/rtl/fpdt_pkg.sv =====
package fpdt_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned SatW     = 32;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // register map
  localparam cfg_idx_t REG_PACING_ENABLE = 2'd0;
  localparam cfg_idx_t REG_PERIOD_WHOLE  = 2'd1;
  localparam cfg_idx_t REG_PERIOD_FRAC   = 2'd2;

endpackage

// ===== hw/rtl/frame_pacing_deadline_timer.sv =====
// Path: input reg, then result reg. Throughput: one frame event request per
// cycle unless out_ready_i stalls; the schedule update (32-bit fraction add,
// TIME_WIDTH-bit deadline add, subtract and compare) completes in the input-to-result stage.
// Reset (rst_ni low, async): pipeline empty, schedule state and config cleared,
// resync pending set so the first frame starts the schedule at its own timestamp.
`include "frame_pacing_deadline_timer_assert.svh"

module frame_pacing_deadline_timer #(
  parameter int unsigned TIME_WIDTH = 63
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  fpdt_pkg::cfg_idx_t                  cfg_index_i,
  input  logic [fpdt_pkg::CfgDataW-1:0]       cfg_wdata_i,
  // frame event requests
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [TIME_WIDTH-1:0]               now_time_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fpdt_pkg::SatW-1:0]           wait_ticks_o,
  output logic [TIME_WIDTH-1:0]               deadline_time_o,
  output logic [fpdt_pkg::SatW-1:0]           frame_interval_o,
  output logic                                interval_valid_o,
  output logic                                resynced_o,
  output logic                                pacing_active_o
);

  localparam int unsigned PW = fpdt_pkg::PeriodW;
  localparam int unsigned SW = fpdt_pkg::SatW;
  // largest value that fits a saturated 32-bit output, at time width
  localparam logic [TIME_WIDTH-1:0] SatT = TIME_WIDTH'(64'hFFFF_FFFF);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic          enable_q;
  logic [PW-1:0] whole_q;
  logic [PW-1:0] frac_q;
  logic          cfg_hit;

  assign cfg_hit = cfg_we_i && ((cfg_index_i == fpdt_pkg::REG_PACING_ENABLE) ||
                                (cfg_index_i == fpdt_pkg::REG_PERIOD_WHOLE)  ||
                                (cfg_index_i == fpdt_pkg::REG_PERIOD_FRAC));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      whole_q  <= '0;
      frac_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fpdt_pkg::REG_PACING_ENABLE: enable_q <= cfg_wdata_i[0];
        fpdt_pkg::REG_PERIOD_WHOLE:  whole_q  <= cfg_wdata_i[PW-1:0];
        fpdt_pkg::REG_PERIOD_FRAC:   frac_q   <= cfg_wdata_i[PW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register (stage 1) feeding the result register (stage 2).
  // Stage 1 drains whenever the result register is empty or being taken, so
  // requests flow one per cycle; while a result waits, stage 1 holds one more.
  // ---------------------------------------------------------------------------
  logic                  in_valid_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  out_valid_q;
  logic                  step;      // stage 1 item moves into the result register
  logic                  in_fire;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q <= now_time_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Schedule state
  // ---------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] last_q,  last_d;
  logic                  have_last_q;
  logic [TIME_WIDTH-1:0] base_q,  base_d;
  logic [PW-1:0]         accum_q, accum_d;
  logic                  pending_q;

  // ---------------------------------------------------------------------------
  // Per-frame computation, all from stage 1 and the schedule state
  // ---------------------------------------------------------------------------
  logic [TIME_WIDTH-1:0] gap;        // now minus previous event
  logic [SW-1:0]         interval;
  logic [TIME_WIDTH-1:0] base_eff;
  logic [PW-1:0]         accum_eff;
  logic                  active;
  logic [PW:0]           frac_sum;   // carry out in the top bit
  logic [TIME_WIDTH-1:0] deadline_raw;
  logic [TIME_WIDTH-1:0] ahead;      // deadline minus now
  logic [TIME_WIDTH-1:0] late;       // now minus deadline
  logic                  is_past;
  logic                  far_behind;
  logic [SW-1:0]         wait_d;
  logic [TIME_WIDTH-1:0] deadline_d;
  logic                  resynced_d;

  always_comb begin
    gap      = now_q - last_q;
    interval = '0;
    if (have_last_q) begin
      interval = (gap > SatT) ? '1 : gap[SW-1:0];
    end

    // a pending resync restarts the schedule at this frame first
    base_eff  = pending_q ? now_q : base_q;
    accum_eff = pending_q ? '0    : accum_q;

    active   = enable_q && (whole_q != '0);
    frac_sum = {1'b0, accum_eff} + {1'b0, frac_q};

    deadline_raw = base_eff + TIME_WIDTH'(whole_q) + TIME_WIDTH'(frac_sum[PW]);
    ahead        = deadline_raw - now_q;
    late         = now_q - deadline_raw;
    is_past      = ahead[TIME_WIDTH-1];
    far_behind   = is_past && (late > TIME_WIDTH'(whole_q));

    wait_d     = '0;
    deadline_d = now_q;
    resynced_d = 1'b0;
    base_d     = now_q;
    accum_d    = '0;
    if (active) begin
      if (far_behind) begin
        // more than one period behind: restart at now
        resynced_d = 1'b1;
      end else begin
        // on time, or slightly late and catching up on the same grid
        deadline_d = deadline_raw;
        base_d     = deadline_raw;
        accum_d    = frac_sum[PW-1:0];
        if (!is_past) begin
          wait_d = (ahead > SatT) ? '1 : ahead[SW-1:0];
        end
      end
    end

    last_d = now_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      have_last_q <= 1'b0;
      base_q      <= '0;
      accum_q     <= '0;
    end else if (step) begin
      last_q      <= last_d;
      have_last_q <= 1'b1;
      base_q      <= base_d;
      accum_q     <= accum_d;
    end
  end

  // any write to a defined register restarts the schedule on the next frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b1;
    end else if (cfg_hit) begin
      pending_q <= 1'b1;
    end else if (step) begin
      pending_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [SW-1:0]         wait_q;
  logic [TIME_WIDTH-1:0] deadline_q;
  logic [SW-1:0]         interval_q;
  logic                  interval_valid_q;
  logic                  resynced_q;
  logic                  active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      wait_q           <= wait_d;
      deadline_q       <= deadline_d;
      interval_q       <= interval;
      interval_valid_q <= have_last_q;
      resynced_q       <= resynced_d;
      active_q         <= active;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign wait_ticks_o     = wait_q;
  assign deadline_time_o  = deadline_q;
  assign frame_interval_o = interval_q;
  assign interval_valid_o = interval_valid_q;
  assign resynced_o       = resynced_q;
  assign pacing_active_o  = active_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `FPDT_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o && !in_valid_q, "busy in reset")
  `FPDT_ASSERT(a_cfg_sets_pending, cfg_hit |=> pending_q, "no resync after config write")
  `FPDT_ASSERT(a_resync_only_active,
               out_valid_o && resynced_o |-> pacing_active_o && (wait_ticks_o == '0),
               "resync without active pacing or with nonzero wait")
  `FPDT_ASSERT(a_inactive_no_wait,
               out_valid_o && !pacing_active_o |->
                 (wait_ticks_o == '0) && (deadline_time_o == last_q),
               "inactive pacing must not wait")
  `FPDT_ASSERT(a_first_interval,
               out_valid_o && !interval_valid_o |-> (frame_interval_o == '0),
               "interval nonzero on first frame")

endmodule
